### hw/rtl/mvn_pkg.sv
package mvn_pkg;

  localparam int MAX_VERTICES_DEF  = 1024;
  localparam int MAX_TRIANGLES_DEF = 2048;

  // action codes
  localparam logic [1:0] ACT_WRITE_VERTEX   = 2'd0;
  localparam logic [1:0] ACT_WRITE_TRIANGLE = 2'd1;
  localparam logic [1:0] ACT_COMPUTE        = 2'd2;
  localparam logic [1:0] ACT_READ_NORMAL    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_VERTEX_COUNT   = 2'd0;
  localparam logic [1:0] CFG_TRIANGLE_COUNT = 2'd1;

  localparam logic STATUS_COMPUTE = 1'b0;
  localparam logic STATUS_READ    = 1'b1;

  localparam int CROSS_W  = 36;   // signed cross product component
  localparam int UNIT_Q14 = 16384;

  // saturating accumulate into a signed 24-bit sum
  function automatic logic [23:0] sat_add24(input logic [23:0] a, input logic [15:0] b);
    logic signed [24:0] s;
    s = $signed({a[23], a}) + $signed({{9{b[15]}}, b});
    if (s > 25'sd8388607)       sat_add24 = 24'h7FFFFF;
    else if (s < -25'sd8388608) sat_add24 = 24'h800000;
    else                        sat_add24 = s[23:0];
  endfunction

endpackage

### hw/rtl/mesh_vertex_normals.sv
// Channel   Direction  Handshake                      Payload
// command   in         start & !busy                  action, slot, coord_x/y/z, corner_a/b/c
// config    in         cfg_write                      cfg_index, cfg_data
// result    out        done (one cycle, no stall)     normal_x/y/z, status
//
// Vertex and triangle writes leave busy low.
// A read does one sum-store read, then runs the normalize unit (magnitude
// shift, 3 squares on one multiplier, 32 square-root steps, then a division
// for each of the 3 components, which a zero sum skips).
// A compute first clears the sum store, then for each triangle in use does
// store reads, 7 multiply steps, the normalize unit and a read-modify-write
// of each corner's sum; a triangle with a corner at or beyond the vertex
// count is skipped.
// After reset the block clears the sum store with busy high.
// The receiver cannot stall: each result shows for exactly one cycle on done.
module mesh_vertex_normals #(
  parameter int MAX_VERTICES  = mvn_pkg::MAX_VERTICES_DEF,
  parameter int MAX_TRIANGLES = mvn_pkg::MAX_TRIANGLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [10:0] slot,
  input  logic [15:0] coord_x,
  input  logic [15:0] coord_y,
  input  logic [15:0] coord_z,
  input  logic [9:0]  corner_a,
  input  logic [9:0]  corner_b,
  input  logic [9:0]  corner_c,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output logic        done,
  output logic [15:0] normal_x,
  output logic [15:0] normal_y,
  output logic [15:0] normal_z,
  output logic        status
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int TW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int CW = mvn_pkg::CROSS_W;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_TRD   = 4'd2;
  localparam logic [3:0] S_TCHK  = 4'd3;
  localparam logic [3:0] S_VA    = 4'd4;
  localparam logic [3:0] S_VB    = 4'd5;
  localparam logic [3:0] S_VC    = 4'd6;
  localparam logic [3:0] S_CROSS = 4'd7;
  localparam logic [3:0] S_NGO   = 4'd8;
  localparam logic [3:0] S_NWAIT = 4'd9;
  localparam logic [3:0] S_ARD   = 4'd10;
  localparam logic [3:0] S_AWR   = 4'd11;
  localparam logic [3:0] S_RSUM  = 4'd12;
  localparam logic [3:0] S_RGO   = 4'd13;
  localparam logic [3:0] S_RWAIT = 4'd14;
  localparam logic [3:0] S_FIN   = 4'd15;

  // stores
  logic [47:0] vert_mem [MAX_VERTICES];
  logic [29:0] tri_mem  [MAX_TRIANGLES];
  logic [71:0] sum_mem  [MAX_VERTICES];

  logic [3:0]    state;
  logic          computing;
  logic [10:0]   vertex_count;
  logic [11:0]   triangle_count;
  logic [VW:0]   clr_idx;
  logic [TW:0]   tri_idx;
  logic [10:0]   rd_slot;
  logic [9:0]    ca, cb, cc;
  logic [1:0]    j;
  logic [2:0]    k;
  logic [47:0]   va, vb;
  logic [16:0]   e1 [3];
  logic [16:0]   e2 [3];
  logic [33:0]   prod;
  logic [CW-1:0] cr [3];
  logic [15:0]   fn [3];

  logic [47:0]   vq;
  logic [29:0]   tq;
  logic [71:0]   sq;

  logic [31:0]   nv, nt;
  logic          accept;
  logic [VW-1:0] vaddr, sum_raddr, sum_waddr;
  logic          sum_we;
  logic [71:0]   sum_wdata;
  logic [9:0]    cur_corner;
  logic [16:0]   mop_a, mop_b;
  logic          ngo;
  logic [CW-1:0] nin_x, nin_y, nin_z;
  logic          ndone;
  logic [15:0]   nres_x, nres_y, nres_z;
  logic          tri_bad;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  assign nv = (32'(vertex_count) < 32'(MAX_VERTICES)) ? 32'(vertex_count) : 32'(MAX_VERTICES);
  assign nt = (32'(triangle_count) < 32'(MAX_TRIANGLES)) ? 32'(triangle_count)
                                                          : 32'(MAX_TRIANGLES);

  assign tri_bad = (32'(tq[29:20]) >= nv) || (32'(tq[19:10]) >= nv) || (32'(tq[9:0]) >= nv);

  always_comb begin
    case (j)
      2'd0:    cur_corner = ca;
      2'd1:    cur_corner = cb;
      default: cur_corner = cc;
    endcase
  end

  // vertex read address: corner a at check, then b, then c
  always_comb begin
    case (state)
      S_TCHK:  vaddr = VW'(32'(tq[29:20]));
      S_VA:    vaddr = VW'(32'(cb));
      default: vaddr = VW'(32'(cc));
    endcase
  end

  assign sum_raddr = (state == S_RSUM) ? VW'(32'(rd_slot)) : VW'(32'(cur_corner));

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = VW'(32'(cur_corner));
    sum_wdata = {mvn_pkg::sat_add24(sq[71:48], fn[0]),
                 mvn_pkg::sat_add24(sq[47:24], fn[1]),
                 mvn_pkg::sat_add24(sq[23:0],  fn[2])};
    if (state == S_CLEAR) begin
      sum_we    = 1'b1;
      sum_waddr = clr_idx[VW-1:0];
      sum_wdata = '0;
    end else if (state == S_AWR) begin
      sum_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && action == mvn_pkg::ACT_WRITE_VERTEX && 32'(slot) < 32'(MAX_VERTICES))
      vert_mem[VW'(32'(slot))] <= {coord_x, coord_y, coord_z};
    vq <= vert_mem[vaddr];
  end

  always_ff @(posedge clk) begin
    if (accept && action == mvn_pkg::ACT_WRITE_TRIANGLE && 32'(slot) < 32'(MAX_TRIANGLES))
      tri_mem[TW'(32'(slot))] <= {corner_a, corner_b, corner_c};
    tq <= tri_mem[tri_idx[TW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    sq <= sum_mem[sum_raddr];
  end

  // cross product operand pairs: y*z, z*y, z*x, x*z, x*y, y*x
  always_comb begin
    case (k)
      3'd0:    begin mop_a = e1[1]; mop_b = e2[2]; end
      3'd1:    begin mop_a = e1[2]; mop_b = e2[1]; end
      3'd2:    begin mop_a = e1[2]; mop_b = e2[0]; end
      3'd3:    begin mop_a = e1[0]; mop_b = e2[2]; end
      3'd4:    begin mop_a = e1[0]; mop_b = e2[1]; end
      default: begin mop_a = e1[1]; mop_b = e2[0]; end
    endcase
  end

  assign ngo   = (state == S_NGO) || (state == S_RGO);
  assign nin_x = (state == S_NGO) ? cr[0] : CW'($signed(sq[71:48]));
  assign nin_y = (state == S_NGO) ? cr[1] : CW'($signed(sq[47:24]));
  assign nin_z = (state == S_NGO) ? cr[2] : CW'($signed(sq[23:0]));

  mvn_norm #(.CW(CW)) u_norm (
    .clk (clk),
    .rst (rst),
    .go  (ngo),
    .cx  (nin_x),
    .cy  (nin_y),
    .cz  (nin_z),
    .done(ndone),
    .nx  (nres_x),
    .ny  (nres_y),
    .nz  (nres_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count   <= 11'd1024;
      triangle_count <= 12'd0;
    end else if (cfg_write) begin
      if (cfg_index == mvn_pkg::CFG_VERTEX_COUNT)   vertex_count   <= cfg_data[10:0];
      if (cfg_index == mvn_pkg::CFG_TRIANGLE_COUNT) triangle_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      computing <= 1'b0;
      clr_idx   <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          // sweep the sums to zero, one entry a cycle
          clr_idx <= clr_idx + 1'b1;
          if (32'(clr_idx) == 32'(MAX_VERTICES - 1)) begin
            if (computing) begin
              tri_idx <= '0;
              state   <= S_TRD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (action == mvn_pkg::ACT_COMPUTE) begin
              computing <= 1'b1;
              clr_idx   <= '0;
              state     <= S_CLEAR;
            end else if (action == mvn_pkg::ACT_READ_NORMAL) begin
              rd_slot <= slot;
              state   <= S_RSUM;
            end
          end
        end
        S_TRD: begin
          if (32'(tri_idx) == nt) state <= S_FIN;
          else                    state <= S_TCHK;
        end
        S_TCHK: begin
          ca <= tq[29:20];
          cb <= tq[19:10];
          cc <= tq[9:0];
          if (tri_bad) begin
            tri_idx <= tri_idx + 1'b1;
            state   <= S_TRD;
          end else begin
            state <= S_VA;
          end
        end
        S_VA: begin
          va    <= vq;
          state <= S_VB;
        end
        S_VB: begin
          vb    <= vq;
          state <= S_VC;
        end
        S_VC: begin
          e1[0] <= {vb[47], vb[47:32]} - {va[47], va[47:32]};
          e1[1] <= {vb[31], vb[31:16]} - {va[31], va[31:16]};
          e1[2] <= {vb[15], vb[15:0]}  - {va[15], va[15:0]};
          e2[0] <= {vq[47], vq[47:32]} - {va[47], va[47:32]};
          e2[1] <= {vq[31], vq[31:16]} - {va[31], va[31:16]};
          e2[2] <= {vq[15], vq[15:0]}  - {va[15], va[15:0]};
          cr[0] <= '0;
          cr[1] <= '0;
          cr[2] <= '0;
          k     <= '0;
          state <= S_CROSS;
        end
        S_CROSS: begin
          // one product a cycle, folded into the component on the next
          if (k != 3'd6) prod <= 34'($signed(mop_a) * $signed(mop_b));
          case (k)
            3'd1:    cr[0] <= cr[0] + CW'($signed(prod));
            3'd2:    cr[0] <= cr[0] - CW'($signed(prod));
            3'd3:    cr[1] <= cr[1] + CW'($signed(prod));
            3'd4:    cr[1] <= cr[1] - CW'($signed(prod));
            3'd5:    cr[2] <= cr[2] + CW'($signed(prod));
            3'd6:    cr[2] <= cr[2] - CW'($signed(prod));
            default: ;
          endcase
          k <= k + 3'd1;
          if (k == 3'd6) state <= S_NGO;
        end
        S_NGO: state <= S_NWAIT;
        S_NWAIT: begin
          if (ndone) begin
            fn[0] <= nres_x;
            fn[1] <= nres_y;
            fn[2] <= nres_z;
            j     <= '0;
            state <= S_ARD;
          end
        end
        S_ARD: state <= S_AWR;
        S_AWR: begin
          // a repeated corner reads back the sum written just before
          if (j == 2'd2) begin
            tri_idx <= tri_idx + 1'b1;
            state   <= S_TRD;
          end else begin
            j     <= j + 2'd1;
            state <= S_ARD;
          end
        end
        S_RSUM: begin
          if (32'(rd_slot) >= nv) begin
            done     <= 1'b1;
            status   <= mvn_pkg::STATUS_READ;
            normal_x <= '0;
            normal_y <= '0;
            normal_z <= '0;
            state    <= S_IDLE;
          end else begin
            state <= S_RGO;
          end
        end
        S_RGO: state <= S_RWAIT;
        S_RWAIT: begin
          if (ndone) begin
            done     <= 1'b1;
            status   <= mvn_pkg::STATUS_READ;
            normal_x <= nres_x;
            normal_y <= nres_y;
            normal_z <= nres_z;
            state    <= S_IDLE;
          end
        end
        S_FIN: begin
          computing <= 1'b0;
          done      <= 1'b1;
          status    <= mvn_pkg::STATUS_COMPUTE;
          normal_x  <= '0;
          normal_y  <= '0;
          normal_z  <= '0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while still busy");

  a_compute_zero: assert property (@(posedge clk) disable iff (rst)
      (done && status == mvn_pkg::STATUS_COMPUTE) |->
      (normal_x == '0 && normal_y == '0 && normal_z == '0))
    else $error("compute result carries a nonzero normal");

  a_norm_owner: assert property (@(posedge clk) disable iff (rst)
      ndone |-> (state == S_NWAIT || state == S_RWAIT))
    else $error("normalize unit finished with nobody waiting");

endmodule

### hw/rtl/mvn_norm.sv
module mvn_norm #(
  parameter int CW = mvn_pkg::CROSS_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic signed [CW-1:0] cx,
  input  logic signed [CW-1:0] cy,
  input  logic signed [CW-1:0] cz,
  output logic                 done,
  output logic [15:0]          nx,
  output logic [15:0]          ny,
  output logic [15:0]          nz
);

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SQRT  = 3'd3;
  localparam logic [2:0] N_DLOAD = 3'd4;
  localparam logic [2:0] N_DSTEP = 3'd5;
  localparam logic [2:0] N_DONE  = 3'd6;

  logic [2:0]    st;
  logic [CW-1:0] m [3];
  logic [2:0]    sg;
  logic [3:0]    cnt;
  logic [1:0]    k;
  logic [59:0]   prod;
  logic [63:0]   ssq;
  logic [63:0]   v;
  logic [63:0]   r;
  logic [63:0]   bitv;
  logic [45:0]   rem;
  logic [45:0]   dv;
  logic [14:0]   q;
  logic [15:0]   res [3];

  logic [29:0]   sq_op;
  logic [63:0]   trial;
  logic          ge;
  logic [14:0]   q_fin;
  logic [14:0]   q_cap;
  logic [31:0]   len;

  assign sq_op = m[cnt[1:0]][29:0];
  assign trial = r + bitv;
  assign len   = r[31:0];
  assign ge    = (rem >= dv);
  assign q_fin = {q[13:0], ge};
  assign q_cap = (q_fin > 15'(mvn_pkg::UNIT_Q14)) ? 15'(mvn_pkg::UNIT_Q14) : q_fin;

  assign done = (st == N_DONE);
  assign nx = res[0];
  assign ny = res[1];
  assign nz = res[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= N_IDLE;
    end else begin
      unique case (st)
        N_IDLE: begin
          if (go) begin
            m[0] <= cx[CW-1] ? CW'(-cx) : CW'(cx);
            m[1] <= cy[CW-1] ? CW'(-cy) : CW'(cy);
            m[2] <= cz[CW-1] ? CW'(-cz) : CW'(cz);
            sg   <= {cz[CW-1], cy[CW-1], cx[CW-1]};
            st   <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          // narrow until the largest magnitude is below 2^30
          if (((m[0] | m[1] | m[2]) >> 30) != '0) begin
            m[0] <= m[0] >> 1;
            m[1] <= m[1] >> 1;
            m[2] <= m[2] >> 1;
          end else begin
            cnt <= '0;
            ssq <= '0;
            st  <= N_SQ;
          end
        end
        N_SQ: begin
          if (cnt != 4'd3) prod <= sq_op * sq_op;
          if (cnt != 4'd0) ssq <= ssq + 64'(prod);
          cnt <= cnt + 4'd1;
          if (cnt == 4'd3) begin
            v    <= ssq + 64'(prod);
            r    <= '0;
            bitv <= 64'd1 << 62;
            st   <= N_SQRT;
          end
        end
        N_SQRT: begin
          if (v >= trial) begin
            v <= v - trial;
            r <= (r >> 1) + bitv;
          end else begin
            r <= r >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            k  <= '0;
            st <= N_DLOAD;
          end
        end
        N_DLOAD: begin
          if (len == '0) begin
            res[0] <= '0;
            res[1] <= '0;
            res[2] <= '0;
            st     <= N_DONE;
          end else begin
            rem <= {m[k][29:0], 14'b0} + 46'(len >> 1);
            dv  <= {len, 14'b0};
            q   <= '0;
            cnt <= 4'd14;
            st  <= N_DSTEP;
          end
        end
        N_DSTEP: begin
          if (ge) rem <= rem - dv;
          dv  <= dv >> 1;
          q   <= q_fin;
          cnt <= cnt - 4'd1;
          if (cnt == 4'd0) begin
            res[k] <= sg[k] ? 16'(-{1'b0, q_cap}) : {1'b0, q_cap};
            if (k == 2'd2) begin
              st <= N_DONE;
            end else begin
              k  <= k + 2'd1;
              st <= N_DLOAD;
            end
          end
        end
        N_DONE: st <= N_IDLE;
        default: st <= N_IDLE;
      endcase
    end
  end

endmodule
